// ===== rtl/tppc_pkg.sv =====
// Shared types, codes and constants for the playback position counter.
// No dependencies; the remainder unit, the top level and the bench files import this package.
package tppc_pkg;

  // Size limits of the song structure
  localparam logic [8:0] MAX_FRAMES = 9'd256;
  localparam logic [8:0] MAX_ROWS   = 9'd256;

  // Event codes carried in the kind field
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_STEP_ROW = 3'd1;
  localparam logic [2:0] KIND_SET_POS  = 3'd2;
  localparam logic [2:0] KIND_QUEUE    = 3'd3;
  localparam logic [2:0] KIND_LOOP_ON  = 3'd4;
  localparam logic [2:0] KIND_BXX      = 3'd5;
  localparam logic [2:0] KIND_CXX      = 3'd6;
  localparam logic [2:0] KIND_DXX      = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_COUNT    = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_SONG_INDEX     = 2'd2;

  // Request into the shared remainder unit
  typedef struct packed {
    logic       start;
    logic [8:0] dividend;
    logic [8:0] divisor;
  } mod_req_t;

  // Response from the shared remainder unit
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  // Full cursor status as reported per event
  typedef struct packed {
    logic [7:0]  cur_frame;
    logic [7:0]  cur_row;
    logic [15:0] cur_tick;
    logic [31:0] frames_total;
    logic [31:0] rows_total;
    logic [31:0] ticks_total;
    logic        queue_valid;
    logic [7:0]  queue_frame;
    logic        loop_on;
    logic [5:0]  song_number;
  } status_t;

  // A zero count acts as one, an oversized count acts as the limit
  function automatic logic [8:0] eff_limit(input logic [8:0] n, input logic [8:0] lim);
    logic [8:0] r;
    r = n;
    if (n == 9'd0) r = 9'd1;
    if (n > lim) r = lim;
    return r;
  endfunction

endpackage

// ===== rtl/tppc_in_if.sv =====
// Event input channel: valid/ready handshake with kind and operands.
// Depends on nothing.
interface tppc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] frame_arg;
  logic [7:0] row_arg;

  modport source (output valid, kind, frame_arg, row_arg, input ready);
  modport sink   (input valid, kind, frame_arg, row_arg, output ready);
endinterface

// ===== rtl/tppc_out_if.sv =====
// Status output channel: valid/ready handshake with the full cursor status.
// Depends on nothing.
interface tppc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cur_frame;
  logic [7:0]  cur_row;
  logic [15:0] cur_tick;
  logic [31:0] frames_total;
  logic [31:0] rows_total;
  logic [31:0] ticks_total;
  logic        queue_valid;
  logic [7:0]  queue_frame;
  logic        loop_on;
  logic [5:0]  song_number;

  modport source (output valid, cur_frame, cur_row, cur_tick, frames_total, rows_total,
                  ticks_total, queue_valid, queue_frame, loop_on, song_number,
                  input ready);
  modport sink   (input valid, cur_frame, cur_row, cur_tick, frames_total, rows_total,
                  ticks_total, queue_valid, queue_frame, loop_on, song_number,
                  output ready);
endinterface

// ===== rtl/tppc_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with index and data.
// Depends on nothing.
interface tppc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tppc_mod.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on tppc_pkg.
module tppc_mod
  import tppc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic       busy_r;
  logic       done_r;
  logic [3:0] cnt_r;
  logic [8:0] quo_r;
  logic [8:0] div_r;
  logic [7:0] rem_r;
  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  // One shift-compare-subtract step
  assign trial = {rem_r, quo_r[8]};
  assign fits  = (trial >= div_r);
  assign diff  = trial - div_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd9;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; remainder stays below the divisor, so 8 bits hold it
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= 8'd0;
    end else if (busy_r) begin
      quo_r <= {quo_r[7:0], 1'b0};
      rem_r <= fits ? diff[7:0] : trial[7:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/tracker_playback_position_counter.sv =====
// Top level of the playback position counter: cursor, totals and sequencer.
// Depends on tppc_pkg, the three channel interfaces and tppc_mod.
//
// Each event transaction returns one status transaction. Events that need no
// modulo (tick, a row step inside the pattern, queue, loop on, Bxx, Cxx) go
// from the idle state straight to the result state; events that compute a frame
// number modulo the frame count (a row step that wraps, set position, Dxx) first
// wait in the modulo state for the 9-step bit-serial remainder unit. The input
// is not ready while an event is being processed; one finished status may wait
// in the output register while the next event is taken.
// Configuration writes are always ready and must be issued while idle.
module tracker_playback_position_counter
  import tppc_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  tppc_in_if.sink     in_ch,
  tppc_out_if.source  out_ch,
  tppc_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;

  logic [8:0]  frame_count_r;
  logic [8:0]  pattern_length_r;
  logic [5:0]  song_index_r;

  logic [7:0]  frame_pos_r;
  logic [7:0]  row_pos_r;
  logic [15:0] tick_pos_r;
  logic [31:0] frames_tot_r;
  logic [31:0] rows_tot_r;
  logic [31:0] ticks_tot_r;
  logic        queued_valid_r;
  logic [7:0]  queued_frame_r;
  logic        loop_flag_r;

  status_t     out_r;
  logic        out_valid_r;

  logic [8:0]  eff_frames;
  logic [8:0]  eff_rows;
  logic [8:0]  frame_lim;
  logic [8:0]  row_lim;
  logic [8:0]  next_cand;
  logic        row_wrap;
  logic        needs_mod;
  logic        in_acc;
  logic        out_load;
  logic [7:0]  bxx_frame;
  logic [7:0]  dxx_row;

  mod_req_t    mod_req;
  mod_rsp_t    mod_rsp;

  tppc_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // Effective limits and candidate values
  assign eff_frames = eff_limit(frame_count_r, MAX_FRAMES);
  assign eff_rows   = eff_limit(pattern_length_r, MAX_ROWS);
  assign frame_lim  = eff_frames - 9'd1;
  assign row_lim    = eff_rows - 9'd1;
  assign row_wrap   = ({1'b0, row_pos_r} + 9'd1) >= eff_rows;
  assign bxx_frame  = ({1'b0, in_ch.frame_arg} <= frame_lim) ? in_ch.frame_arg
                                                              : frame_lim[7:0];
  assign dxx_row    = ({1'b0, in_ch.row_arg} <= row_lim) ? in_ch.row_arg : row_lim[7:0];

  always_comb begin
    if (queued_valid_r) next_cand = {1'b0, queued_frame_r};
    else if (loop_flag_r) next_cand = {1'b0, frame_pos_r};
    else next_cand = {1'b0, frame_pos_r} + 9'd1;
  end

  // Handshakes
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign needs_mod = (in_ch.kind == KIND_SET_POS) || (in_ch.kind == KIND_DXX) ||
                     ((in_ch.kind == KIND_STEP_ROW) && row_wrap);

  // Remainder unit request
  assign mod_req.start    = in_acc && needs_mod;
  assign mod_req.dividend = (in_ch.kind == KIND_SET_POS) ? {1'b0, in_ch.frame_arg} : next_cand;
  assign mod_req.divisor  = eff_frames;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = needs_mod ? ST_MOD : ST_DONE;
      ST_MOD:  if (mod_rsp.done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r    <= 9'd1;
      pattern_length_r <= 9'd64;
      song_index_r     <= 6'd0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_FRAME_COUNT:    frame_count_r    <= cfg_ch.data;
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_ch.data;
        CFG_SONG_INDEX:     song_index_r     <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  // Cursor and totals; the frame number of a modulo event arrives later from the remainder unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r    <= 8'd0;
      row_pos_r      <= 8'd0;
      tick_pos_r     <= 16'd0;
      frames_tot_r   <= 32'd0;
      rows_tot_r     <= 32'd0;
      ticks_tot_r    <= 32'd0;
      queued_valid_r <= 1'b0;
      queued_frame_r <= 8'd0;
      loop_flag_r    <= 1'b0;
    end else if (in_acc) begin
      unique case (in_ch.kind)
        KIND_TICK: begin
          tick_pos_r  <= tick_pos_r + 16'd1;
          ticks_tot_r <= ticks_tot_r + 32'd1;
        end
        KIND_STEP_ROW: begin
          if (row_wrap) begin
            row_pos_r      <= 8'd0;
            queued_valid_r <= 1'b0;
            frames_tot_r   <= frames_tot_r + 32'd1;
          end else begin
            row_pos_r <= row_pos_r + 8'd1;
          end
          rows_tot_r <= rows_tot_r + 32'd1;
          tick_pos_r <= 16'd0;
        end
        KIND_SET_POS: begin
          row_pos_r  <= in_ch.row_arg;
          tick_pos_r <= 16'd0;
        end
        KIND_QUEUE: begin
          queued_frame_r <= in_ch.frame_arg;
          queued_valid_r <= 1'b1;
        end
        KIND_LOOP_ON: loop_flag_r <= 1'b1;
        KIND_BXX: begin
          frame_pos_r  <= bxx_frame;
          frames_tot_r <= frames_tot_r + 32'd1;
          row_pos_r    <= 8'd0;
          rows_tot_r   <= rows_tot_r + 32'd1;
          tick_pos_r   <= 16'd0;
        end
        KIND_CXX: frames_tot_r <= frames_tot_r + 32'd1;
        KIND_DXX: begin
          queued_valid_r <= 1'b0;
          frames_tot_r   <= frames_tot_r + 32'd1;
          row_pos_r      <= dxx_row;
          rows_tot_r     <= rows_tot_r + 32'd1;
          tick_pos_r     <= 16'd0;
        end
        default: ;
      endcase
    end else if (state_r == ST_MOD && mod_rsp.done) begin
      frame_pos_r <= mod_rsp.rem;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  // Status snapshot
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.cur_frame    <= frame_pos_r;
      out_r.cur_row      <= row_pos_r;
      out_r.cur_tick     <= tick_pos_r;
      out_r.frames_total <= frames_tot_r;
      out_r.rows_total   <= rows_tot_r;
      out_r.ticks_total  <= ticks_tot_r;
      out_r.queue_valid  <= queued_valid_r;
      out_r.queue_frame  <= queued_frame_r;
      out_r.loop_on      <= loop_flag_r;
      out_r.song_number  <= song_index_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cur_frame    = out_r.cur_frame;
  assign out_ch.cur_row      = out_r.cur_row;
  assign out_ch.cur_tick     = out_r.cur_tick;
  assign out_ch.frames_total = out_r.frames_total;
  assign out_ch.rows_total   = out_r.rows_total;
  assign out_ch.ticks_total  = out_r.ticks_total;
  assign out_ch.queue_valid  = out_r.queue_valid;
  assign out_ch.queue_frame  = out_r.queue_frame;
  assign out_ch.loop_on      = out_r.loop_on;
  assign out_ch.song_number  = out_r.song_number;

  // Remainder result only lands while the sequencer waits for it
  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> state_r == ST_MOD)
    else $error("remainder done outside the wait state");

  // While waiting, the remainder unit is working or just finished
  a_mod_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOD |-> (mod_rsp.busy || mod_rsp.done))
    else $error("sequencer waits on an idle remainder unit");

  // A pending status is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("status register loaded while a result is pending");

  // An event without a modulo reaches the result stage next cycle
  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !needs_mod) |=> state_r == ST_DONE)
    else $error("short event did not move to the result stage");

endmodule

// ===== bench/tppc_status_checker.sv =====
// Status checker for the playback position counter: watches the event, status and
// configuration channels, predicts each status transaction and compares it.
// Depends on tppc_pkg and the three channel interfaces.
`timescale 1ns / 100ps

module tppc_status_checker
  import tppc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tppc_in_if   in_ch,
  tppc_out_if  out_ch,
  tppc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  // Register shadows
  logic [8:0]  reg_frames;
  logic [8:0]  reg_rows;
  logic [5:0]  reg_song;

  // Cursor and totals as the block should hold them
  logic [7:0]  pos_frame;
  logic [7:0]  pos_row;
  logic [15:0] pos_tick;
  logic [31:0] tot_frames;
  logic [31:0] tot_rows;
  logic [31:0] tot_ticks;
  logic        q_valid;
  logic [7:0]  q_frame;
  logic        looping;

  status_t     status_q[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  // Zero acts as one, oversized acts as the limit
  function automatic int frames_eff();
    if (reg_frames == 9'd0) return 1;
    if (reg_frames > MAX_FRAMES) return int'(MAX_FRAMES);
    return int'(reg_frames);
  endfunction

  function automatic int rows_eff();
    if (reg_rows == 9'd0) return 1;
    if (reg_rows > MAX_ROWS) return int'(MAX_ROWS);
    return int'(reg_rows);
  endfunction

  task automatic enter_frame(input int f);
    pos_frame  = 8'(f % frames_eff());
    tot_frames = tot_frames + 32'd1;
  endtask

  // Queued frame wins, then loop keeps the frame, else advance
  task automatic take_next_frame();
    int f;
    if (q_valid) begin
      f = int'(q_frame);
      q_valid = 1'b0;
    end else if (looping) begin
      f = int'(pos_frame);
    end else begin
      f = int'(pos_frame) + 1;
    end
    enter_frame(f);
  endtask

  task automatic enter_row(input int r);
    pos_row  = 8'(r);
    tot_rows = tot_rows + 32'd1;
    pos_tick = 16'd0;
  endtask

  task automatic apply_event(input logic [2:0] kind, input logic [7:0] farg,
                             input logic [7:0] rarg, output status_t st);
    int lim;
    case (kind)
      KIND_TICK: begin
        pos_tick  = pos_tick + 16'd1;
        tot_ticks = tot_ticks + 32'd1;
      end
      KIND_STEP_ROW: begin
        if (int'(pos_row) + 1 >= rows_eff()) begin
          pos_row = 8'd0;
          take_next_frame();
        end else begin
          pos_row = pos_row + 8'd1;
        end
        tot_rows = tot_rows + 32'd1;
        pos_tick = 16'd0;
      end
      KIND_SET_POS: begin
        pos_frame = 8'(int'(farg) % frames_eff());
        pos_row   = rarg;
        pos_tick  = 16'd0;
      end
      KIND_QUEUE: begin
        q_frame = farg;
        q_valid = 1'b1;
      end
      KIND_LOOP_ON: begin
        looping = 1'b1;
      end
      KIND_BXX: begin
        lim = frames_eff() - 1;
        enter_frame((int'(farg) <= lim) ? int'(farg) : lim);
        enter_row(0);
      end
      KIND_CXX: begin
        tot_frames = tot_frames + 32'd1;
      end
      default: begin
        lim = rows_eff() - 1;
        take_next_frame();
        enter_row((int'(rarg) <= lim) ? int'(rarg) : lim);
      end
    endcase
    st.cur_frame    = pos_frame;
    st.cur_row      = pos_row;
    st.cur_tick     = pos_tick;
    st.frames_total = tot_frames;
    st.rows_total   = tot_rows;
    st.ticks_total  = tot_ticks;
    st.queue_valid  = q_valid;
    st.queue_frame  = q_frame;
    st.loop_on      = looping;
    st.song_number  = reg_song;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("status mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic compare_status(input status_t want, input status_t got);
    check_field("cur_frame", 32'(want.cur_frame), 32'(got.cur_frame));
    check_field("cur_row", 32'(want.cur_row), 32'(got.cur_row));
    check_field("cur_tick", 32'(want.cur_tick), 32'(got.cur_tick));
    check_field("frames_total", want.frames_total, got.frames_total);
    check_field("rows_total", want.rows_total, got.rows_total);
    check_field("ticks_total", want.ticks_total, got.ticks_total);
    check_field("queue_valid", 32'(want.queue_valid), 32'(got.queue_valid));
    check_field("queue_frame", 32'(want.queue_frame), 32'(got.queue_frame));
    check_field("loop_on", 32'(want.loop_on), 32'(got.loop_on));
    check_field("song_number", 32'(want.song_number), 32'(got.song_number));
  endtask

  // Retire status first, then config writes, then predict new events
  always @(posedge clk) begin : watch
    status_t seen;
    status_t want;
    if (!rst_n) begin
      reg_frames = 9'd1;
      reg_rows   = 9'd64;
      reg_song   = 6'd0;
      pos_frame  = 8'd0;
      pos_row    = 8'd0;
      pos_tick   = 16'd0;
      tot_frames = 32'd0;
      tot_rows   = 32'd0;
      tot_ticks  = 32'd0;
      q_valid    = 1'b0;
      q_frame    = 8'd0;
      looping    = 1'b0;
      status_q.delete();
      pending <= 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.cur_frame    = out_ch.cur_frame;
        seen.cur_row      = out_ch.cur_row;
        seen.cur_tick     = out_ch.cur_tick;
        seen.frames_total = out_ch.frames_total;
        seen.rows_total   = out_ch.rows_total;
        seen.ticks_total  = out_ch.ticks_total;
        seen.queue_valid  = out_ch.queue_valid;
        seen.queue_frame  = out_ch.queue_frame;
        seen.loop_on      = out_ch.loop_on;
        seen.song_number  = out_ch.song_number;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status transaction: frame %0h row %0h",
                     seen.cur_frame, seen.cur_row);
        end else begin
          want = status_q.pop_front();
          compare_status(want, seen);
        end
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          CFG_FRAME_COUNT:    reg_frames = cfg_ch.data;
          CFG_PATTERN_LENGTH: reg_rows   = cfg_ch.data;
          CFG_SONG_INDEX:     reg_song   = cfg_ch.data[5:0];
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        apply_event(in_ch.kind, in_ch.frame_arg, in_ch.row_arg, want);
        status_q.push_back(want);
      end
      pending <= status_q.size();
    end
  end

endmodule

// ===== bench/tracker_playback_position_counter_test.sv =====
// Top of the playback position counter regression: clock, reset, event and config
// stimulus, random stalls on the status side, and the verdict.
// Depends on tppc_pkg, the channel interfaces, the block and tppc_status_checker.
`timescale 1ns / 100ps

module tracker_playback_position_counter_test;
  import tppc_pkg::*;

  // Index past the last register, must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic       clk;
  logic       rst_n;
  bit         calm;
  int         fail_count;
  int         pending;
  int         stall_left;
  logic [8:0] cur_fc;
  logic [8:0] cur_pl;

  tppc_in_if  in_ch();
  tppc_out_if out_ch();
  tppc_cfg_if cfg_ch();

  tracker_playback_position_counter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tppc_status_checker status_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tracker_playback_position_counter regression: fail");
    $finish;
  end

  // Status side: ready with random stall bursts, none once calm
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 8) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // One event transaction, then maybe an idle burst
  task automatic send_event(input logic [2:0] kind, input logic [7:0] farg,
                            input logic [7:0] rarg);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.frame_arg <= farg;
    in_ch.row_arg   <= rarg;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (!calm && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every status has come back, then let the block settle
  task automatic drain_status();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Register write; valid is left high for back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic configure(input logic [8:0] fc, input logic [8:0] pl, input logic [8:0] song);
    drain_status();
    write_reg(CFG_FRAME_COUNT, fc);
    write_reg(CFG_PATTERN_LENGTH, pl);
    write_reg(CFG_SONG_INDEX, song);
    write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
    cfg_ch.valid <= 1'b0;
    cur_fc = fc;
    cur_pl = pl;
  endtask

  // Operand: half full range, half close to the active limit
  function automatic logic [7:0] near_arg(input logic [8:0] reg_val);
    int n;
    n = (reg_val == 9'd0) ? 1 : ((reg_val > 9'd256) ? 256 : int'(reg_val));
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
    return 8'($urandom_range((n > 2) ? n - 2 : 0, (n > 254) ? 255 : n + 1));
  endfunction

  task automatic random_event(input bit allow_loop);
    int         pick;
    logic [2:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 25)      kind = KIND_TICK;
    else if (pick < 55) kind = KIND_STEP_ROW;
    else if (pick < 63) kind = KIND_SET_POS;
    else if (pick < 70) kind = KIND_QUEUE;
    else if (pick < 73) kind = allow_loop ? KIND_LOOP_ON : KIND_TICK;
    else if (pick < 80) kind = KIND_BXX;
    else if (pick < 87) kind = KIND_CXX;
    else                kind = KIND_DXX;
    send_event(kind, near_arg(cur_fc), near_arg(cur_pl));
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_TICK;
    in_ch.frame_arg <= 8'd0;
    in_ch.row_arg   <= 8'd0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_FRAME_COUNT;
    cfg_ch.data     <= 9'd0;
    rst_n           <= 1'b0;
    calm   = 1'b0;
    cur_fc = 9'd1;
    cur_pl = 9'd64;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one frame, 64 rows; row past the pattern wraps on next step
    send_event(KIND_TICK, 8'd0, 8'd0);
    send_event(KIND_STEP_ROW, 8'd0, 8'd0);
    send_event(KIND_SET_POS, 8'hFF, 8'hFF);
    send_event(KIND_STEP_ROW, 8'd0, 8'd0);

    // Largest song: frame wrap past 255, clamps at the top, queue taken and cleared
    configure(9'd256, 9'd256, 9'd63);
    send_event(KIND_SET_POS, 8'hFF, 8'hFF);
    send_event(KIND_STEP_ROW, 8'd0, 8'd0);
    send_event(KIND_DXX, 8'd0, 8'hFF);
    send_event(KIND_BXX, 8'hFF, 8'd0);
    send_event(KIND_BXX, 8'd0, 8'd0);
    send_event(KIND_QUEUE, 8'd200, 8'd0);
    send_event(KIND_SET_POS, 8'd0, 8'hFF);
    send_event(KIND_STEP_ROW, 8'd0, 8'd0);
    send_event(KIND_QUEUE, 8'd7, 8'd0);
    send_event(KIND_DXX, 8'd0, 8'd0);
    send_event(KIND_CXX, 8'd0, 8'd0);

    // Zero registers act as one
    configure(9'd0, 9'd0, 9'h12A);
    send_event(KIND_STEP_ROW, 8'd0, 8'd0);
    send_event(KIND_BXX, 8'hFF, 8'd0);
    send_event(KIND_DXX, 8'd0, 8'hFF);
    send_event(KIND_SET_POS, 8'hFF, 8'd0);

    // Oversized registers act as the maximum
    configure(9'd511, 9'd300, 9'd21);
    send_event(KIND_SET_POS, 8'hFF, 8'd0);
    send_event(KIND_STEP_ROW, 8'd0, 8'd0);
    send_event(KIND_QUEUE, 8'h55, 8'd0);
    send_event(KIND_TICK, 8'd0, 8'd0);

    // Random phases; loop stays off until late since it never clears
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(9'd256, 9'd256, 9'd63);
        1: configure(9'd2, 9'd2, 9'($urandom_range(0, 511)));
        2: configure(9'($urandom_range(1, 256)), 9'($urandom_range(1, 16)),
                     9'($urandom_range(0, 511)));
        3: configure(9'd0, 9'd0, 9'($urandom_range(0, 511)));
        4: configure(9'($urandom_range(257, 511)), 9'($urandom_range(257, 511)),
                     9'($urandom_range(0, 511)));
        5: configure(9'd1, 9'd1, 9'd0);
        6: configure(9'($urandom_range(3, 40)), 9'($urandom_range(2, 8)),
                     9'($urandom_range(0, 511)));
        default: configure(9'd256, 9'($urandom_range(1, 64)), 9'($urandom_range(0, 511)));
      endcase
      if (phase == 6) send_event(KIND_LOOP_ON, 8'd0, 8'd0);
      if (phase == 7) calm = 1'b1;
      repeat (144) random_event(phase >= 6);
    end

    drain_status();
    if (fail_count == 0 && pending == 0) begin
      $display("tracker_playback_position_counter regression: pass");
    end else begin
      $display("tracker_playback_position_counter regression: fail");
    end
    $finish;
  end

endmodule
